/* src/lif_neuron_step_core_defines.svh */
// Assertion macros for the LIF neuron step core.
// Used by the sequencer and datapath; expects clk and rst_n in scope.
`ifndef LIF_NEURON_STEP_CORE_DEFINES_SVH
`define LIF_NEURON_STEP_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// checked only out of reset
`define LIFN_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lifn assertion failed");
// checked on every edge, reset included
`define LIFN_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("lifn assertion failed");
`else
`define LIFN_ASSERT(lbl, prop)
`define LIFN_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

/* src/lifn_pkg.sv */
// Shared types, codes and helpers of the LIF neuron step core.
// No dependencies; imported by the sequencer, datapath and top level.
package lifn_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_DECAY     = 3'd0;
  localparam logic [2:0] REG_IN_GAIN   = 3'd1;
  localparam logic [2:0] REG_BIAS      = 3'd2;
  localparam logic [2:0] REG_NOISE_G   = 3'd3;
  localparam logic [2:0] REG_THRESHOLD = 3'd4;
  localparam logic [2:0] REG_RESET_POT = 3'd5;
  localparam logic [2:0] REG_REFR      = 3'd6;

  // datapath operations
  localparam logic [3:0] OP_NONE       = 4'd0;
  localparam logic [3:0] OP_LOAD       = 4'd1;
  localparam logic [3:0] OP_MUL_NOISE  = 4'd2;
  localparam logic [3:0] OP_DRIVE      = 4'd3;
  localparam logic [3:0] OP_MUL_GAIN   = 4'd4;
  localparam logic [3:0] OP_GAIN_DECAY = 4'd5;
  localparam logic [3:0] OP_UPDATE     = 4'd6;
  localparam logic [3:0] OP_EMIT       = 4'd7;
  localparam logic [3:0] OP_REFR       = 4'd8;
  localparam logic [3:0] OP_FIRE       = 4'd9;

  // jump conditions
  localparam logic [2:0] C_NONE     = 3'd0;
  localparam logic [2:0] C_ITEM     = 3'd1;
  localparam logic [2:0] C_REFR     = 3'd2;
  localparam logic [2:0] C_FIRE     = 3'd3;
  localparam logic [2:0] C_OUT_FREE = 3'd4;

  // program steps
  localparam logic [3:0] S_WAIT   = 4'd0;
  localparam logic [3:0] S_TEST_R = 4'd1;
  localparam logic [3:0] S_TEST_F = 4'd2;
  localparam logic [3:0] S_MUL_N  = 4'd3;
  localparam logic [3:0] S_DRIVE  = 4'd4;
  localparam logic [3:0] S_MUL_G  = 4'd5;
  localparam logic [3:0] S_MUL_D  = 4'd6;
  localparam logic [3:0] S_UPDATE = 4'd7;
  localparam logic [3:0] S_EMIT   = 4'd8;
  localparam logic [3:0] S_REFR   = 4'd9;
  localparam logic [3:0] S_FIRE   = 4'd10;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] cond;
    logic [3:0] tgt;   // taken when cond holds
    logic [3:0] nxt;   // otherwise
  } ucode_t;

  typedef struct packed {
    logic item_avail;
    logic refr_pend;
    logic at_thresh;
    logic out_free;
  } stat_t;

  function automatic ucode_t ucode_rom(input logic [3:0] pc);
    ucode_t w;
    case (pc)
      S_WAIT:   w = '{OP_LOAD,       C_ITEM,     S_TEST_R, S_WAIT};
      S_TEST_R: w = '{OP_NONE,       C_REFR,     S_REFR,   S_TEST_F};
      S_TEST_F: w = '{OP_NONE,       C_FIRE,     S_FIRE,   S_MUL_N};
      S_MUL_N:  w = '{OP_MUL_NOISE,  C_NONE,     S_WAIT,   S_DRIVE};
      S_DRIVE:  w = '{OP_DRIVE,      C_NONE,     S_WAIT,   S_MUL_G};
      S_MUL_G:  w = '{OP_MUL_GAIN,   C_NONE,     S_WAIT,   S_MUL_D};
      S_MUL_D:  w = '{OP_GAIN_DECAY, C_NONE,     S_WAIT,   S_UPDATE};
      S_UPDATE: w = '{OP_UPDATE,     C_NONE,     S_WAIT,   S_EMIT};
      S_EMIT:   w = '{OP_EMIT,       C_OUT_FREE, S_WAIT,   S_EMIT};
      S_REFR:   w = '{OP_REFR,       C_NONE,     S_WAIT,   S_EMIT};
      S_FIRE:   w = '{OP_FIRE,       C_NONE,     S_WAIT,   S_EMIT};
      default:  w = '{OP_NONE,       C_NONE,     S_WAIT,   S_WAIT};
    endcase
    return w;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [47:0] x);
    logic [31:0] r;
    if (!x[47] && (|x[46:31])) begin
      r = 32'h7FFF_FFFF;
    end else if (x[47] && !(&x[46:31])) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

/* src/lifn_in_if.sv */
// Input channel of the LIF neuron step core: one time step per item.
// Valid/ready handshake; no dependencies.
interface lifn_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] synaptic_current;
  logic signed [15:0] noise_sample;

  modport source (output valid, output synaptic_current, output noise_sample, input ready);
  modport sink   (input valid, input synaptic_current, input noise_sample, output ready);
endinterface

/* src/lifn_out_if.sv */
// Result channel of the LIF neuron step core: one result item per step.
// Valid/ready handshake; no dependencies.
interface lifn_out_if;
  logic               valid;
  logic               ready;
  logic               fired;
  logic signed [31:0] membrane_potential;
  logic        [31:0] spike_count;
  logic               refractory_active;

  modport source (output valid, output fired, output membrane_potential,
                  output spike_count, output refractory_active, input ready);
  modport sink   (input valid, input fired, input membrane_potential,
                  input spike_count, input refractory_active, output ready);
endinterface

/* src/lifn_seq.sv */
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on lifn_pkg and lif_neuron_step_core_defines.svh.
`include "lif_neuron_step_core_defines.svh"
module lifn_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  lifn_pkg::stat_t stat,
  output logic [3:0]     op,
  output logic           in_ready
);
  import lifn_pkg::*;

  logic [3:0] pc_r;
  logic [3:0] pc_nxt;
  ucode_t     word;
  logic       taken;

  assign word = ucode_rom(pc_r);

  always_comb begin
    case (word.cond)
      C_NONE:     taken = 1'b0;
      C_ITEM:     taken = stat.item_avail;
      C_REFR:     taken = stat.refr_pend;
      C_FIRE:     taken = stat.at_thresh;
      C_OUT_FREE: taken = stat.out_free;
      default:    taken = 1'b0;
    endcase
    pc_nxt = taken ? word.tgt : word.nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign op       = word.op;
  assign in_ready = (pc_r == S_WAIT);

  `LIFN_ASSERT(a_accept_leaves_wait, (pc_r == S_WAIT && stat.item_avail) |=> pc_r == S_TEST_R)
  `LIFN_ASSERT(a_emit_waits_slot, (pc_r == S_EMIT && !stat.out_free) |=> pc_r == S_EMIT)
  `LIFN_ASSERT_ALWAYS(a_pc_in_program, !rst_n || pc_r <= S_FIRE)

endmodule

/* src/lifn_dp.sv */
// Datapath: config registers, neuron state, one shared 33x33 multiplier
// and the result register. Depends on lifn_pkg and the defines header.
`include "lif_neuron_step_core_defines.svh"
module lifn_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [3:0]         op,
  output lifn_pkg::stat_t    stat,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  input  logic signed [31:0] in_current,
  input  logic signed [15:0] in_noise,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_fired,
  output logic signed [31:0] out_potential,
  output logic [31:0]        out_count,
  output logic               out_refr
);
  import lifn_pkg::*;

  // configuration
  logic        [16:0] decay_r;
  logic signed [31:0] in_gain_r;
  logic signed [31:0] bias_r;
  logic signed [31:0] noise_gain_r;
  logic signed [31:0] thresh_r;
  logic signed [31:0] reset_pot_r;
  logic        [15:0] refr_steps_r;

  // neuron state
  logic signed [31:0] pot_r;
  logic        [15:0] refr_left_r;
  logic        [31:0] spike_r;

  // working registers
  logic signed [31:0] cur_r;
  logic signed [15:0] noise_r;
  logic signed [65:0] prod_r;
  logic signed [31:0] drive_r;
  logic signed [39:0] acc_r;
  logic               fired_r;
  logic               refr_flag_r;

  logic               out_valid_r;
  logic               out_fired_r;
  logic signed [31:0] out_pot_r;
  logic        [31:0] out_count_r;
  logic               out_refr_r;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic               mul_en;
  logic signed [47:0] noise_rnd;
  logic signed [37:0] drive_sum;
  logic signed [63:0] gain_rnd;
  logic signed [49:0] decay_rnd;
  logic signed [40:0] upd_sum;
  logic               out_free;
  logic               out_load;

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b0;
    case (op)
      OP_MUL_NOISE: begin
        mul_a  = 33'(noise_r);
        mul_b  = 33'(noise_gain_r);
        mul_en = 1'b1;
      end
      OP_MUL_GAIN: begin
        mul_a  = 33'(in_gain_r);
        mul_b  = 33'(drive_r);
        mul_en = 1'b1;
      end
      OP_GAIN_DECAY: begin
        mul_a  = $signed({16'd0, decay_r});
        mul_b  = 33'(pot_r);
        mul_en = 1'b1;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // round half up, then floor shift
  assign noise_rnd = prod_r[47:0] + 48'sd2048;
  assign drive_sum = 38'(cur_r) + 38'(bias_r) + 38'($signed(noise_rnd[47:12]));
  assign gain_rnd  = prod_r[63:0] + 64'sd8388608;
  assign decay_rnd = prod_r[49:0] + 50'sd32768;
  assign upd_sum   = 41'(acc_r) + 41'($signed(decay_rnd[49:16]));

  assign out_free = !out_valid_r || out_ready;
  assign out_load = (op == OP_EMIT) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_r      <= '0;
      in_gain_r    <= '0;
      bias_r       <= '0;
      noise_gain_r <= '0;
      thresh_r     <= '0;
      reset_pot_r  <= '0;
      refr_steps_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DECAY:     decay_r      <= cfg_wdata[16:0];
        REG_IN_GAIN:   in_gain_r    <= cfg_wdata;
        REG_BIAS:      bias_r       <= cfg_wdata;
        REG_NOISE_G:   noise_gain_r <= cfg_wdata;
        REG_THRESHOLD: thresh_r     <= cfg_wdata;
        REG_RESET_POT: reset_pot_r  <= cfg_wdata;
        REG_REFR:      refr_steps_r <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pot_r       <= '0;
      refr_left_r <= '0;
      spike_r     <= '0;
      fired_r     <= 1'b0;
      refr_flag_r <= 1'b0;
    end else begin
      case (op)
        OP_LOAD: begin
          fired_r     <= 1'b0;
          refr_flag_r <= 1'b0;
        end
        OP_REFR: begin
          refr_left_r <= refr_left_r - 16'd1;
          refr_flag_r <= 1'b1;
        end
        OP_FIRE: begin
          if (spike_r != '1) begin
            spike_r <= spike_r + 32'd1;
          end
          refr_left_r <= refr_steps_r;
          pot_r       <= reset_pot_r;
          fired_r     <= 1'b1;
        end
        OP_UPDATE: begin
          pot_r <= sat32({{7{upd_sum[40]}}, upd_sum});
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (op == OP_LOAD) begin
      cur_r   <= in_current;
      noise_r <= in_noise;
    end
    if (mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    if (op == OP_DRIVE) begin
      drive_r <= sat32({{10{drive_sum[37]}}, drive_sum});
    end
    if (op == OP_GAIN_DECAY) begin
      acc_r <= gain_rnd[63:24];
    end
    if (out_load) begin
      out_fired_r <= fired_r;
      out_pot_r   <= pot_r;
      out_count_r <= spike_r;
      out_refr_r  <= refr_flag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat = '{in_valid, (refr_left_r != 16'd0), (pot_r >= thresh_r), out_free};

  assign out_valid     = out_valid_r;
  assign out_fired     = out_fired_r;
  assign out_potential = out_pot_r;
  assign out_count     = out_count_r;
  assign out_refr      = out_refr_r;

  `LIFN_ASSERT(a_spike_monotonic, $past(rst_n) |-> spike_r >= $past(spike_r))
  `LIFN_ASSERT(a_fire_xor_refr, out_valid_r |-> !(out_fired_r && out_refr_r))
  `LIFN_ASSERT(a_refr_no_fire, (op == OP_REFR) |=> !fired_r && (spike_r == $past(spike_r)))

endmodule

/* src/lif_neuron_step_core.sv */
// LIF neuron step core: one item is one time step of a single neuron.
// The core takes a new item only in its wait step, after it has emitted the result of the last;
// an integrate step makes three dependent passes through the shared multiplier.
// A result still held on the output stalls the sequencer in its emit step.
// Reset (synchronous, rst_n low): config registers, potential, countdown and count go to zero.
module lif_neuron_step_core (
  input  logic        clk,
  input  logic        rst_n,
  lifn_in_if.sink     in_ch,
  lifn_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import lifn_pkg::*;

  stat_t      stat;
  logic [3:0] op;

  lifn_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .stat     (stat),
    .op       (op),
    .in_ready (in_ch.ready)
  );

  lifn_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .op            (op),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_ch.valid),
    .in_current    (in_ch.synaptic_current),
    .in_noise      (in_ch.noise_sample),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_fired     (out_ch.fired),
    .out_potential (out_ch.membrane_potential),
    .out_count     (out_ch.spike_count),
    .out_refr      (out_ch.refractory_active)
  );

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for lif_neuron_step_core: drives neuron time steps and register
// writes, predicts every result item and compares it field by field.
// Needs lifn_pkg, lifn_in_if, lifn_out_if and the core itself.

module tb;
  import lifn_pkg::*;

  localparam logic [2:0] REG_SPARE = 3'd7;  // unmapped index, write must be ignored
  localparam int QUIET_LIMIT = 4000;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic signed [31:0] current;
    logic signed [15:0] noise;
  } step_input_t;

  typedef struct packed {
    logic               fired;
    logic signed [31:0] potential;
    logic        [31:0] spikes;
    logic               refr;
  } step_result_t;

  typedef struct packed {
    logic [31:0] decay, gain, bias, noise_gain, thresh, reset_pot, refr;
  } neuron_cfg_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_DECAY;
  logic [31:0] cfg_wdata = '0;

  lifn_in_if  step_in ();
  lifn_out_if step_out ();

  lif_neuron_step_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (step_in),
    .out_ch    (step_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // register copies and neuron state as the bench sees them
  logic        [16:0] decay_q = '0;
  logic signed [31:0] gain_q = '0, bias_q = '0, noise_gain_q = '0;
  logic signed [31:0] thresh_q = '0, reset_pot_q = '0;
  logic        [15:0] refr_steps_q = '0;
  logic signed [31:0] pot_now = '0;
  logic        [15:0] refr_left = '0;
  logic        [31:0] spikes_now = '0;

  step_input_t  pending_steps[$];
  step_result_t expected_steps[$];

  int steps_queued = 0;
  int steps_accepted = 0;
  int results_seen = 0;
  int mismatch_count = 0;
  int send_gap = 0;
  int recv_stall = 0;
  int quiet_cycles = 0;
  bit no_idle = 1'b0;
  bit long_stall_due = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic signed [31:0] clamp_q824(input longint x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // one time step of the neuron; rounding is half up, then floor
  task automatic advance_neuron(input step_input_t s);
    longint v, noise_t, drive, gain_t, decay_t;
    step_result_t r;
    r = '0;
    v = longint'(pot_now);
    if (refr_left != 16'd0) begin
      refr_left = refr_left - 16'd1;
      r.refr = 1'b1;
    end else if (pot_now >= thresh_q) begin
      r.fired = 1'b1;
      if (spikes_now != 32'hFFFF_FFFF) spikes_now = spikes_now + 32'd1;
      refr_left = refr_steps_q;
      pot_now = reset_pot_q;
    end else begin
      noise_t = (longint'($signed(s.noise)) * longint'(noise_gain_q) + 64'sd2048) >>> 12;
      drive = longint'(clamp_q824(longint'($signed(s.current)) + longint'(bias_q) + noise_t));
      gain_t = (longint'(gain_q) * drive + 64'sd8388608) >>> 24;
      decay_t = (longint'(decay_q) * v + 64'sd32768) >>> 16;
      pot_now = clamp_q824(decay_t + gain_t);
    end
    r.potential = pot_now;
    r.spikes = spikes_now;
    expected_steps = {expected_steps, r};
  endtask

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("[%0t] step result error: %s", $time, what);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_DECAY:     decay_q = val[16:0];
      REG_IN_GAIN:   gain_q = val;
      REG_BIAS:      bias_q = val;
      REG_NOISE_G:   noise_gain_q = val;
      REG_THRESHOLD: thresh_q = val;
      REG_RESET_POT: reset_pot_q = val;
      REG_REFR:      refr_steps_q = val[15:0];
      default: ;
    endcase
  endtask

  task automatic apply_cfg(input neuron_cfg_t c);
    write_reg(REG_DECAY, c.decay);
    write_reg(REG_IN_GAIN, c.gain);
    write_reg(REG_BIAS, c.bias);
    write_reg(REG_NOISE_G, c.noise_gain);
    write_reg(REG_THRESHOLD, c.thresh);
    write_reg(REG_RESET_POT, c.reset_pot);
    write_reg(REG_REFR, c.refr);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_step(input logic signed [31:0] cur, input logic signed [15:0] ns);
    step_input_t s;
    s.current = cur;
    s.noise = ns;
    pending_steps = {pending_steps, s};
    steps_queued++;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (steps_accepted != steps_queued || expected_steps.size() != 0);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    else if (r < 88) return $urandom_range(3, 1);
    else if (r < 97) return $urandom_range(10, 4);
    else return $urandom_range(60, 20);
  endfunction

  // tame items keep the neuron in its working range so that it fires now and then
  function automatic step_input_t gen_step(input bit wild);
    step_input_t s;
    s.noise = 16'($urandom());
    if (wild) s.current = $urandom();
    else s.current = $urandom_range(32'h0600_0000) - 32'h0100_0000;
    return s;
  endfunction

  function automatic neuron_cfg_t gen_cfg(input bit wild);
    neuron_cfg_t c;
    if (wild) begin
      c.decay = $urandom();
      c.gain = $urandom();
      c.bias = $urandom();
      c.noise_gain = $urandom();
      c.thresh = $urandom();
      c.reset_pot = $urandom();
      c.refr = ($urandom() & 32'hFFFF_0000) | $urandom_range(3);
    end else begin
      c.decay = $urandom_range(65536, 45875);
      c.gain = $urandom_range(32'h0100_0000, 32'h0008_0000);
      c.bias = $urandom_range(32'h0080_0000) - 32'h0040_0000;
      c.noise_gain = $urandom_range(32'h0020_0000) - 32'h0010_0000;
      c.thresh = $urandom_range(32'h0400_0000, 32'h0040_0000);
      c.reset_pot = $urandom_range(32'h0100_0000) - 32'h0080_0000;
      c.refr = ($urandom_range(9) == 0) ? $urandom_range(30, 10) : $urandom_range(4);
    end
    return c;
  endfunction

  // driver: offers queued steps, predicts each one as it is taken
  always @(posedge clk) begin : drive_steps
    step_input_t nxt;
    if (!rst_n) begin
      step_in.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (step_in.valid && step_in.ready) begin
        advance_neuron('{step_in.synaptic_current, step_in.noise_sample});
        steps_accepted++;
      end
      if (!step_in.valid || step_in.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          step_in.valid <= 1'b0;
        end else if (pending_steps.size() > 0) begin
          nxt = pending_steps.pop_front();
          step_in.valid <= 1'b1;
          step_in.synaptic_current <= nxt.current;
          step_in.noise_sample <= nxt.noise;
          send_gap = no_idle ? 0 : pick_gap();
        end else begin
          step_in.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result item against the oldest prediction
  always @(posedge clk) begin : collect_results
    step_result_t want;
    if (!rst_n) begin
      step_out.ready <= 1'b0;
    end else begin
      if (step_out.valid && step_out.ready) begin
        results_seen++;
        if (results_seen % 400 == 100) long_stall_due = 1'b1;
        if (expected_steps.size() == 0) begin
          report_mismatch($sformatf("result %0d with no step outstanding", results_seen));
        end else begin
          want = expected_steps.pop_front();
          if (step_out.fired !== want.fired)
            report_mismatch($sformatf("result %0d fired %b, want %b",
                                      results_seen, step_out.fired, want.fired));
          if (step_out.membrane_potential !== want.potential)
            report_mismatch($sformatf("result %0d potential %h, want %h", results_seen,
                                      step_out.membrane_potential, want.potential));
          if (step_out.spike_count !== want.spikes)
            report_mismatch($sformatf("result %0d spike count %0d, want %0d",
                                      results_seen, step_out.spike_count, want.spikes));
          if (step_out.refractory_active !== want.refr)
            report_mismatch($sformatf("result %0d refractory %b, want %b", results_seen,
                                      step_out.refractory_active, want.refr));
        end
      end
      // long hold-off only while the sender still has plenty to push
      if (long_stall_due && pending_steps.size() > 20) begin
        long_stall_due = 1'b0;
        recv_stall = 300;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        step_out.ready <= 1'b0;
      end else if (no_idle || $urandom_range(99) < 80) begin
        step_out.ready <= 1'b1;
      end else begin
        recv_stall = pick_gap();
        step_out.ready <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((step_in.valid && step_in.ready) || (step_out.valid && step_out.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    step_input_t s;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // registers at reset: potential 0 meets threshold 0, so every step fires
    queue_step(32'sh0000_0000, 16'sh0000);
    queue_step(32'sh7FFF_FFFF, 16'sh7FFF);
    wait_drained();

    // no drive at all: potential holds at zero, longest refractory period never loaded
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    apply_cfg('{32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0000_FFFF});
    queue_step(32'sh8000_0000, 16'sh8000);
    queue_step(32'sh7FFF_FFFF, 16'sh7FFF);
    wait_drained();

    // unit gains: drive and potential saturate both ways; zero refractory period
    apply_cfg('{32'h0001_0000, 32'h0100_0000, 32'h0, 32'h0100_0000,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h0});
    queue_step(32'sh7FFF_FFFF, 16'sh7FFF);
    queue_step(32'sh0000_0000, 16'sh0000);
    queue_step(32'sh8000_0000, 16'sh8000);
    queue_step(32'sh0000_0000, 16'sh0000);
    queue_step(32'sh7FFF_FFFF, 16'sh0000);
    wait_drained();

    // decay above one: potential grows until it fires, then two refractory steps
    apply_cfg('{32'h0001_FFFF, 32'h0010_0000, 32'h0010_0000, 32'hFFF0_0000,
                32'h4000_0000, 32'h0001_0000, 32'h2});
    for (int i = 0; i < 8; i++) queue_step(32'sh7FFF_FFFF, i[0] ? 16'sh7FFF : 16'sh8000);
    wait_drained();

    // lowest threshold: fire and refractory alternate
    apply_cfg('{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h7FFF_FFFF, 32'h1});
    queue_step(32'sh8000_0000, 16'sh8000);
    queue_step(32'sh7FFF_FFFF, 16'sh7FFF);
    queue_step(32'sh0000_0000, 16'sh0000);
    queue_step(32'shFFFF_FFFF, 16'shFFFF);
    wait_drained();

    for (int ph = 0; ph < 10; ph++) begin
      apply_cfg(gen_cfg(ph % 4 == 3));
      no_idle = (ph % 5 == 2);
      // sender drains completely between the two halves of a phase
      for (int half = 0; half < 2; half++) begin
        repeat (100) begin
          s = gen_step($urandom_range(99) < 15);
          queue_step(s.current, s.noise);
        end
        wait_drained();
      end
    end
    no_idle = 1'b0;

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_steps.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/lifn_pkg.sv
src/lifn_in_if.sv
src/lifn_out_if.sv
src/lifn_seq.sv
src/lifn_dp.sv
src/lif_neuron_step_core.sv
sim/tb.sv
